>>> design/bsb_pkg.sv
// Package: shared types and constants for the Brownian step block.
`default_nettype none
package bsb_pkg;
    localparam int unsigned XW = 20;
    localparam int unsigned YW = 16;
    localparam int unsigned RW = 14;
    localparam int unsigned AW = 16;
    localparam int unsigned FW = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_AMPLITUDE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT = 2'd2;
    localparam logic [15:0] RST_STEP_AMPLITUDE = 16'd2560;
    localparam logic [19:0] RST_BOX_WIDTH = 20'd768000;
    localparam logic [15:0] RST_BOX_HEIGHT = 16'd25600;

    typedef struct packed {
        logic [XW-1:0] x;
        logic [YW-1:0] y;
        logic [RW-1:0] rad;
        logic [31:0]   amp;
        logic [14:0]   cmag;
        logic          cneg;
        logic [14:0]   smag;
        logic          sneg;
    } req_t;
endpackage
`default_nettype wire

>>> design/bsb_front.sv
// Front: accepts requests, computes amplitude product and quarter-wave sine terms.
`default_nettype none
module bsb_front #(
    parameter int unsigned ANGLE_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic [19:0]          x_position,
    input  wire logic [15:0]          y_position,
    input  wire logic [13:0]          radius,
    input  wire logic [15:0]          angle_fraction,
    input  wire logic [15:0]          amplitude_factor,
    input  wire logic [15:0]          step_amplitude,
    output logic                      out_valid,
    output bsb_pkg::req_t             out_req
);
    localparam logic [15:0] AMASK = 16'hFFFF << (16 - ANGLE_BITS);

    // stage 1: z = u*u, amplitude product
    logic        v1_reg;
    logic [19:0] x1_reg;
    logic [15:0] y1_reg;
    logic [13:0] r1_reg;
    logic [31:0] amp1_reg;
    logic [1:0]  q1_reg;
    logic [14:0] ut1_reg, uc1_reg;
    logic [15:0] zt1_reg, zc1_reg;
    // stage 2: inner term times z
    logic        v2_reg;
    bsb_pkg::req_t p2_reg;
    bsb_pkg::req_t p2_next;
    logic [1:0]  q2_reg;
    logic [14:0] ut2_reg, uc2_reg;
    logic [15:0] pt2_reg, pc2_reg;
    // stage 3: u*poly
    logic        v3_reg;
    bsb_pkg::req_t p3_reg;
    bsb_pkg::req_t p3_next;

    logic [15:0] a;
    logic [14:0] t, tc;
    logic [29:0] zt_full, zc_full;
    logic [31:0] it, ic, mt, mc;
    logic [14:0] it_s, ic_s;
    logic [30:0] st_full, sc_full;
    logic [14:0] st, sc;

    always_comb
    begin
        a = angle_fraction & AMASK;
        t = {1'b0, a[13:0]};
        tc = 15'd16384 - t;
        zt_full = 30'(t) * 30'(t);
        zc_full = 30'(tc) * 30'(tc);
    end

    always_comb
    begin
        it_s = 15'(16'd10512 - 16'((32'(zt1_reg) * 32'd1160) >> 14));
        ic_s = 15'(16'd10512 - 16'((32'(zc1_reg) * 32'd1160) >> 14));
        it = 32'(zt1_reg) * 32'(it_s);
        ic = 32'(zc1_reg) * 32'(ic_s);
        mt = it >> 14;
        mc = ic >> 14;
        st_full = 31'(ut2_reg) * 31'(pt2_reg);
        sc_full = 31'(uc2_reg) * 31'(pc2_reg);
        st = 15'(st_full >> 14);
        sc = 15'(sc_full >> 14);
    end

    always_comb
    begin
        p2_next = '0;
        p2_next.x = x1_reg;
        p2_next.y = y1_reg;
        p2_next.rad = r1_reg;
        p2_next.amp = amp1_reg;

        p3_next = p2_reg;
        unique case (q2_reg)
            2'd0:
            begin
                p3_next.cmag = sc; p3_next.cneg = 1'b0;
                p3_next.smag = st; p3_next.sneg = 1'b0;
            end
            2'd1:
            begin
                p3_next.cmag = st; p3_next.cneg = 1'b1;
                p3_next.smag = sc; p3_next.sneg = 1'b0;
            end
            2'd2:
            begin
                p3_next.cmag = sc; p3_next.cneg = 1'b1;
                p3_next.smag = st; p3_next.sneg = 1'b1;
            end
            default:
            begin
                p3_next.cmag = st; p3_next.cneg = 1'b0;
                p3_next.smag = sc; p3_next.sneg = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg <= x_position;
        y1_reg <= y_position;
        r1_reg <= radius;
        amp1_reg <= 32'(step_amplitude) * 32'(amplitude_factor);
        q1_reg <= a[15:14];
        ut1_reg <= t;
        uc1_reg <= tc;
        zt1_reg <= 16'(zt_full >> 14);
        zc1_reg <= 16'(zc_full >> 14);

        p2_reg <= p2_next;
        q2_reg <= q1_reg;
        ut2_reg <= ut1_reg;
        uc2_reg <= uc1_reg;
        pt2_reg <= 16'(32'd25736 - mt);
        pc2_reg <= 16'(32'd25736 - mc);

        p3_reg <= p3_next;
    end

    assign out_valid = v3_reg;
    assign out_req = p3_reg;
endmodule
`default_nettype wire

>>> design/bsb_queue.sv
// Short register queue between front and back.
`default_nettype none
module bsb_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  bsb_pkg::req_t      in_req,
    output logic               out_valid,
    output bsb_pkg::req_t      out_req
);
    logic          v_reg;
    bsb_pkg::req_t d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            d_reg <= in_req;
        end
    end

    assign out_valid = v_reg;
    assign out_req = d_reg;
endmodule
`default_nettype wire

>>> design/bsb_back.sv
// Back: scales steps, wraps x, reflects y, and applies the acceptance test.
`default_nettype none
module bsb_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  bsb_pkg::req_t      in_req,
    input  wire logic [19:0]   box_width,
    input  wire logic [15:0]   box_height,
    output logic               done,
    output logic [19:0]        new_x,
    output logic [15:0]        new_y,
    output logic               moved
);
    // stage A: products
    logic          va_reg;
    bsb_pkg::req_t ra_reg;
    logic [46:0]   px_reg, py_reg;
    // stage B: signed steps and new positions
    logic          vb_reg;
    logic [19:0]   xb_reg;
    logic [15:0]   yb_reg;
    logic [13:0]   rb_reg;
    logic signed [24:0] xn_reg, yn_reg, yr_reg;
    // output
    logic          vo_reg;
    logic [19:0]   xo_reg;
    logic [15:0]   yo_reg;
    logic          mo_reg;

    logic [21:0] mx, my;
    logic signed [24:0] dx, dy;
    logic signed [24:0] w, h, r, xw, yf;
    logic ok;

    always_comb
    begin
        mx = 22'((px_reg + 47'(1 << 25)) >> 26);
        my = 22'((py_reg + 47'(1 << 25)) >> 26);
        dx = ra_reg.cneg ? -$signed({3'b0, mx}) : $signed({3'b0, mx});
        dy = ra_reg.sneg ? -$signed({3'b0, my}) : $signed({3'b0, my});
        w = $signed({5'b0, box_width});
        h = $signed({9'b0, box_height});
        r = $signed({11'b0, rb_reg});
        xw = xn_reg;
        if (xw > w)
        begin
            xw = xw - w;
        end
        if (xw < 0)
        begin
            xw = xw + w;
        end
        yf = (yn_reg > h - r || yn_reg < r) ? yr_reg : yn_reg;
        ok = (yf < h - r) && (yf > r) && (xw < w) && (xw > 0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vo_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ra_reg <= in_req;
        px_reg <= 47'(in_req.amp) * 47'(in_req.cmag);
        py_reg <= 47'(in_req.amp) * 47'(in_req.smag);

        xb_reg <= ra_reg.x;
        yb_reg <= ra_reg.y;
        rb_reg <= ra_reg.rad;
        xn_reg <= $signed({5'b0, ra_reg.x}) + dx;
        yn_reg <= $signed({9'b0, ra_reg.y}) + dy;
        yr_reg <= $signed({9'b0, ra_reg.y}) - dy;

        xo_reg <= ok ? 20'(xw) : xb_reg;
        yo_reg <= ok ? 16'(yf) : yb_reg;
        mo_reg <= ok;
    end

    assign done = vo_reg;
    assign new_x = xo_reg;
    assign new_y = yo_reg;
    assign moved = mo_reg;
endmodule
`default_nettype wire

>>> design/brownian_step_with_boundaries.sv
// Top level: Brownian particle step in a periodic-x, reflective-y box.
// Throughput: one request per cycle.
// Front is a 3-stage sine/amplitude pipe, one queue register, back is 3 stages.
// busy is always low; the receiver cannot stall, done strobes one cycle.
// Reset (async, active low) clears valid bits and loads register defaults.
`default_nettype none
module brownian_step_with_boundaries #(
    parameter int unsigned ANGLE_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [19:0] x_position,
    input  wire logic [15:0] y_position,
    input  wire logic [13:0] radius,
    input  wire logic [15:0] angle_fraction,
    input  wire logic [15:0] amplitude_factor,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [19:0] cfg_data,
    output logic             done,
    output logic [19:0]      new_x,
    output logic [15:0]      new_y,
    output logic             moved
);
    logic [15:0] amp_reg;
    logic [19:0] width_reg;
    logic [15:0] height_reg;
    logic          f_valid, q_valid;
    bsb_pkg::req_t f_req, q_req;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_reg <= bsb_pkg::RST_STEP_AMPLITUDE;
            width_reg <= bsb_pkg::RST_BOX_WIDTH;
            height_reg <= bsb_pkg::RST_BOX_HEIGHT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bsb_pkg::REG_STEP_AMPLITUDE: amp_reg <= cfg_data[15:0];
                bsb_pkg::REG_BOX_WIDTH: width_reg <= cfg_data;
                bsb_pkg::REG_BOX_HEIGHT: height_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    bsb_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
        .clk, .rst_n, .in_valid(start && !busy),
        .x_position, .y_position, .radius, .angle_fraction, .amplitude_factor,
        .step_amplitude(amp_reg), .out_valid(f_valid), .out_req(f_req)
    );

    bsb_queue u_queue (
        .clk, .rst_n, .in_valid(f_valid), .in_req(f_req),
        .out_valid(q_valid), .out_req(q_req)
    );

    bsb_back u_back (
        .clk, .rst_n, .in_valid(q_valid), .in_req(q_req),
        .box_width(width_reg), .box_height(height_reg),
        .done, .new_x, .new_y, .moved
    );
endmodule
`default_nettype wire

>>> design/bsb_checker.sv
// Port-level checker for the Brownian step block, bound to the top level.
`default_nettype none
module bsb_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [19:0] x_position,
    input wire logic [15:0] y_position,
    input wire logic [19:0] new_x,
    input wire logic [15:0] new_y,
    input wire logic        moved
);
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##7 done) else $error("missing result");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 7)) else $error("spurious result");
    a_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !moved) |-> (new_x == $past(x_position, 7) && new_y == $past(y_position, 7)))
        else $error("rejected move changed position");
    a_x_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (done && moved) |-> new_x != 20'd0) else $error("accepted x on boundary");
endmodule

bind brownian_step_with_boundaries bsb_checker u_bsb_checker (
    .clk, .rst_n, .start, .busy, .done, .x_position, .y_position,
    .new_x, .new_y, .moved
);
`default_nettype wire

>>> dv/brownian_step_with_boundaries_tb.sv
// Testbench for the Brownian step block: queued requests, in-bench position predictor.
`timescale 1ns / 1ps
module brownian_step_with_boundaries_tb;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [19:0] x;
        logic [15:0] y;
        logic [13:0] rad;
        logic [15:0] ang;
        logic [15:0] fac;
    } particle_t;

    typedef struct packed {
        logic [19:0] x;
        logic [15:0] y;
        logic        moved;
    } position_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [19:0] x_position;
    logic [15:0] y_position;
    logic [13:0] radius;
    logic [15:0] angle_fraction;
    logic [15:0] amplitude_factor;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [19:0] cfg_data;
    logic        done;
    logic [19:0] new_x;
    logic [15:0] new_y;
    logic        moved;

    particle_t pending_q[$];
    position_t expected_q[$];
    logic [15:0] amp_reg;
    logic [19:0] width_reg;
    logic [15:0] height_reg;
    int mismatches;
    int cycles;
    bit quiet;
    int gap;

    brownian_step_with_boundaries u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .x_position(x_position), .y_position(y_position), .radius(radius),
        .angle_fraction(angle_fraction), .amplitude_factor(amplitude_factor),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .new_x(new_x), .new_y(new_y), .moved(moved)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint unsigned qsine(longint unsigned u);
        longint unsigned z;
        longint unsigned inner;
        longint unsigned poly;
        z = (u * u) >> 14;
        inner = 10512 - ((z * 1160) >> 14);
        poly = 25736 - ((z * inner) >> 14);
        return (u * poly) >> 14;
    endfunction

    function automatic position_t predict_move(particle_t p);
        position_t res;
        longint unsigned a;
        longint unsigned t;
        longint unsigned st;
        longint unsigned sc;
        longint unsigned cm;
        longint unsigned sm;
        longint unsigned amp;
        longint dx;
        longint dy;
        longint xn;
        longint yn;
        longint w;
        longint h;
        longint r;
        bit cn;
        bit sn;
        a = p.ang;
        t = a & 16'h3FFF;
        st = qsine(t);
        sc = qsine(16384 - t);
        case (a[15:14])
            2'd0: begin cm = sc; cn = 0; sm = st; sn = 0; end
            2'd1: begin cm = st; cn = 1; sm = sc; sn = 0; end
            2'd2: begin cm = sc; cn = 1; sm = st; sn = 1; end
            default: begin cm = st; cn = 0; sm = sc; sn = 1; end
        endcase
        amp = longint'(amp_reg) * p.fac;
        dx = longint'((amp * cm + (64'd1 << 25)) >> 26);
        dy = longint'((amp * sm + (64'd1 << 25)) >> 26);
        if (cn) dx = -dx;
        if (sn) dy = -dy;
        w = width_reg;
        h = height_reg;
        r = p.rad;
        xn = longint'(p.x) + dx;
        yn = longint'(p.y) + dy;
        if (xn > w) xn -= w;
        if (xn < 0) xn += w;
        if (yn > h - r || yn < r) yn = longint'(p.y) - dy;
        if (yn < h - r && yn > r && xn < w && xn > 0)
        begin
            res.x = xn[19:0];
            res.y = yn[15:0];
            res.moved = 1'b1;
        end
        else
        begin
            res.x = p.x;
            res.y = p.y;
            res.moved = 1'b0;
        end
        return res;
    endfunction

    // driver: accepted when start & !busy at rising edge; predict on acceptance
    always @(posedge clk)
    begin
        if (start && !busy && rst_n)
        begin
            expected_q = {expected_q, predict_move(pending_q.pop_front())};
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (start && busy)
        begin
            start <= 1'b1;
        end
        else if (gap > 0)
        begin
            gap = gap - 1;
            start <= 1'b0;
        end
        else if (pending_q.size() > 0 && !(!quiet && $urandom_range(0, 7) == 0))
        begin
            start <= 1'b1;
            x_position <= pending_q[0].x;
            y_position <= pending_q[0].y;
            radius <= pending_q[0].rad;
            angle_fraction <= pending_q[0].ang;
            amplitude_factor <= pending_q[0].fac;
        end
        else
        begin
            if (pending_q.size() > 0) gap = $urandom_range(0, 3);
            start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        position_t e;
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result x=%0d y=%0d", new_x, new_y);
            end
            else
            begin
                e = expected_q.pop_front();
                if (e.x !== new_x || e.y !== new_y || e.moved !== moved)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp x=%0d y=%0d m=%0d got x=%0d y=%0d m=%0d",
                                 e.x, e.y, e.moved, new_x, new_y, moved);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [19:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == bsb_pkg::REG_STEP_AMPLITUDE) amp_reg = val[15:0];
        else if (idx == bsb_pkg::REG_BOX_WIDTH) width_reg = val;
        else if (idx == bsb_pkg::REG_BOX_HEIGHT) height_reg = val[15:0];
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || expected_q.size() > 0 || start) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic add_particle(logic [19:0] x, logic [15:0] y, logic [13:0] r,
                                logic [15:0] a, logic [15:0] f);
        particle_t p;
        p = '{x: x, y: y, rad: r, ang: a, fac: f};
        pending_q = {pending_q, p};
    endtask

    // mostly in-box particles, some fully random
    task automatic random_batch(int n);
        int i;
        logic [13:0] r;
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 4) == 0)
                add_particle(20'($urandom), 16'($urandom), 14'($urandom), 16'($urandom),
                             16'($urandom));
            else
            begin
                r = 14'($urandom_range(0, height_reg / 4));
                add_particle(20'($urandom_range(0, width_reg)),
                             16'($urandom_range(0, height_reg)), r,
                             16'($urandom), 16'($urandom_range(2048, 6144)));
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        x_position = '0;
        y_position = '0;
        radius = '0;
        angle_fraction = '0;
        amplitude_factor = '0;
        mismatches = 0;
        cycles = 0;
        gap = 0;
        quiet = 0;
        amp_reg = bsb_pkg::RST_STEP_AMPLITUDE;
        width_reg = bsb_pkg::RST_BOX_WIDTH;
        height_reg = bsb_pkg::RST_BOX_HEIGHT;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // directed: quadrant edges, field extremes, wrap, reflection, rejection
        add_particle(20'd1000, 16'd12800, 14'd100, 16'h0000, 16'd4096);
        add_particle(20'd1000, 16'd12800, 14'd100, 16'h4000, 16'd4096);
        add_particle(20'd1000, 16'd12800, 14'd100, 16'h8000, 16'd4096);
        add_particle(20'd1000, 16'd12800, 14'd100, 16'hC000, 16'd4096);
        add_particle(20'd1000, 16'd12800, 14'd100, 16'hFFFF, 16'hFFFF);
        add_particle(20'd1, 16'd12800, 14'd0, 16'h8000, 16'd4096);
        add_particle(20'd767999, 16'd12800, 14'd0, 16'h0000, 16'd4096);
        add_particle(20'd5000, 16'd25000, 14'd300, 16'h4000, 16'd4096);
        add_particle(20'd5000, 16'd400, 14'd300, 16'hC000, 16'd4096);
        add_particle(20'hFFFFF, 16'hFFFF, 14'h3FFF, 16'h2000, 16'd0);
        add_particle(20'd0, 16'd0, 14'd0, 16'h1234, 16'd4096);
        add_particle(20'd5000, 16'd12800, 14'd12800, 16'h1000, 16'd4096);
        drain();
        write_reg(bsb_pkg::REG_STEP_AMPLITUDE, 20'hFFFFF);
        write_reg(bsb_pkg::REG_BOX_WIDTH, 20'hFFFFF);
        write_reg(bsb_pkg::REG_BOX_HEIGHT, 20'hFFFFF);
        add_particle(20'd500000, 16'd30000, 14'd10, 16'h0100, 16'd1);
        add_particle(20'd500000, 16'd30000, 14'd10, 16'h9000, 16'hFFFF);
        random_batch(300);
        drain();
        write_reg(bsb_pkg::REG_STEP_AMPLITUDE, 20'd0);
        write_reg(bsb_pkg::REG_BOX_WIDTH, 20'd1);
        write_reg(bsb_pkg::REG_BOX_HEIGHT, 20'd1);
        write_reg(REG_UNUSED, 20'd12345);
        random_batch(50);
        drain();
        write_reg(bsb_pkg::REG_STEP_AMPLITUDE, 20'd300);
        write_reg(bsb_pkg::REG_BOX_WIDTH, 20'd4000);
        write_reg(bsb_pkg::REG_BOX_HEIGHT, 20'd2000);
        random_batch(350);
        drain();
        write_reg(bsb_pkg::REG_STEP_AMPLITUDE, 20'(bsb_pkg::RST_STEP_AMPLITUDE));
        write_reg(bsb_pkg::REG_BOX_WIDTH, bsb_pkg::RST_BOX_WIDTH);
        write_reg(bsb_pkg::REG_BOX_HEIGHT, 20'(bsb_pkg::RST_BOX_HEIGHT));
        random_batch(200);
        drain();
        quiet = 1;
        random_batch(200);
        drain();
        if (mismatches == 0 && expected_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
